FILE: hdl/vsar_pkg.sv
// Package: command codes, state type and widths for the scroll address registers.
package vsar_pkg;

    localparam int CMD_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 15;
    localparam int ACCESS_W = 14;
    localparam int FINE_W   = 3;

    localparam logic [CMD_W-1:0] CMD_CTRL   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADDR   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DATA   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_STATUS = 4'd4;
    localparam logic [CMD_W-1:0] CMD_COARSE = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FINE_Y = 4'd6;
    localparam logic [CMD_W-1:0] CMD_HCOPY  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_VCOPY  = 4'd8;

    localparam logic [4:0] COARSE_LAST = 5'd31;
    localparam logic [4:0] ROW_WRAP    = 5'd30;
    localparam logic [2:0] FINE_LAST   = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] temp_addr;
        logic [ADDR_W-1:0] cur_addr;
        logic [FINE_W-1:0] fine_x;
        logic              toggle;
        logic              step_by_row;
        logic              line12_flag;
    } t_state;

endpackage

FILE: hdl/vsar_if.sv
// Interfaces: command word channel and result word channel.
interface vsar_in_if;
    import vsar_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface vsar_out_if;
    import vsar_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   vram_addr;
    logic [ACCESS_W-1:0] access_addr;
    logic                access_valid;
    logic [FINE_W-1:0]   fine_x_scroll;
    logic                write_toggle;
    logic                addr_bit12;
    modport source (output valid, output vram_addr, output access_addr,
                    output access_valid, output fine_x_scroll,
                    output write_toggle, output addr_bit12, input ready);
    modport sink   (input valid, input vram_addr, input access_addr,
                    input access_valid, input fine_x_scroll,
                    input write_toggle, input addr_bit12, output ready);
endinterface

FILE: hdl/video_scroll_address_registers.sv
// Top level: scroll and address registers of a tile video processor.
//
// Usage:
//   i_in carries one command word (cmd, data_byte) per handshake; o_out
//   returns exactly one result word for each command, in order.
//   A command passes an input register, then the state update and the
//   result register, which raises o_out.valid.
//   Throughput is one command per cycle while results are taken; the state
//   registers update in the same cycle the result register loads, so
//   back-to-back commands see each other's effects with no bubble.
//   While a result waits with o_out.ready low the result register holds; an
//   empty input register still takes one more word, after which i_in.ready
//   drops until the result is taken.
//   Reset (i_rst_n low, synchronous) clears the temp and current addresses,
//   fine X, the write toggle, the increment mode and the line twelve flag,
//   and empties both registers.
module video_scroll_address_registers
    import vsar_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    vsar_in_if.sink    i_in,
    vsar_out_if.source o_out
);

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_data_byte;
    logic              r_out_valid;
    t_state            r_state;
    t_state            n_state;
    logic [ACCESS_W-1:0] n_access_addr;
    logic                n_access_valid;
    logic [ACCESS_W-1:0] r_access_addr;
    logic                r_access_valid;
    logic                advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    vsar_step u_step (
        .i_state        (r_state),
        .i_cmd          (r_cmd),
        .i_data_byte    (r_data_byte),
        .o_state        (n_state),
        .o_access_addr  (n_access_addr),
        .o_access_valid (n_access_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_cmd       <= i_in.cmd;
            r_data_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_access_addr  <= n_access_addr;
            r_access_valid <= n_access_valid;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.vram_addr     = r_state.cur_addr;
    assign o_out.access_addr   = r_access_addr;
    assign o_out.access_valid  = r_access_valid;
    assign o_out.fine_x_scroll = r_state.fine_x;
    assign o_out.write_toggle  = r_state.toggle;
    assign o_out.addr_bit12    = r_state.line12_flag;

endmodule

FILE: hdl/vsar_step.sv
// Next-state logic: applies one command word to the scroll address state.
module vsar_step
    import vsar_pkg::*;
(
    input  t_state              i_state,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [BYTE_W-1:0]   i_data_byte,
    output t_state              o_state,
    output logic [ACCESS_W-1:0] o_access_addr,
    output logic                o_access_valid
);

    logic [ADDR_W-1:0]   cur;
    logic [ADDR_W-1:0]   tmp;
    logic [4:0]          row;
    logic [4:0]          row_inc;
    logic [ACCESS_W-1:0] stepped;
    logic [ADDR_W-1:0]   fy_addr;

    assign cur     = i_state.cur_addr;
    assign tmp     = i_state.temp_addr;
    assign row     = cur[9:5];
    assign row_inc = row + 5'd1;
    assign stepped = cur[ACCESS_W-1:0]
                   + (i_state.step_by_row ? ACCESS_W'(32) : ACCESS_W'(1));

    always_comb begin
        fy_addr = cur;
        if (cur[14:12] == FINE_LAST) begin
            if (row == COARSE_LAST) begin
                fy_addr[9:0] = 10'd0;
            end else if (row_inc >= ROW_WRAP) begin
                fy_addr[9:0] = 10'd0;
                fy_addr[11]  = ~cur[11];
            end else begin
                fy_addr[9:5] = row_inc;
            end
        end
        fy_addr[14:12] = cur[14:12] + 3'd1;
    end

    always_comb begin
        o_state        = i_state;
        o_access_addr  = '0;
        o_access_valid = 1'b0;
        unique case (i_cmd)
            CMD_CTRL: begin
                o_state.temp_addr[11:10] = i_data_byte[1:0];
                o_state.step_by_row      = i_data_byte[2];
            end
            CMD_SCROLL: begin
                if (i_state.toggle) begin
                    o_state.temp_addr[9:5]   = i_data_byte[7:3];
                    o_state.temp_addr[14:12] = i_data_byte[2:0];
                end else begin
                    o_state.temp_addr[4:0] = i_data_byte[7:3];
                    o_state.fine_x         = i_data_byte[2:0];
                end
                o_state.toggle = ~i_state.toggle;
            end
            CMD_ADDR: begin
                if (i_state.toggle) begin
                    o_state.temp_addr   = {tmp[14:8], i_data_byte};
                    o_state.cur_addr    = {tmp[14:8], i_data_byte};
                    o_state.line12_flag = tmp[12];
                end else begin
                    o_state.temp_addr = {1'b0, i_data_byte[5:0], tmp[7:0]};
                end
                o_state.toggle = ~i_state.toggle;
            end
            CMD_DATA: begin
                o_access_addr       = cur[ACCESS_W-1:0];
                o_access_valid      = 1'b1;
                o_state.cur_addr    = {1'b0, stepped};
                o_state.line12_flag = stepped[12];
            end
            CMD_STATUS: begin
                o_state.toggle = 1'b0;
            end
            CMD_COARSE: begin
                if (cur[4:0] == COARSE_LAST) begin
                    o_state.cur_addr = {cur[14:11], ~cur[10], cur[9:5], 5'd0};
                end else begin
                    o_state.cur_addr = {cur[14:5], cur[4:0] + 5'd1};
                end
            end
            CMD_FINE_Y: begin
                o_state.cur_addr = fy_addr;
            end
            CMD_HCOPY: begin
                o_state.cur_addr = {cur[14:11], tmp[10], cur[9:5], tmp[4:0]};
            end
            CMD_VCOPY: begin
                o_state.cur_addr = tmp;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

FILE: test/video_scroll_address_registers_tb.sv
// Testbench: random and directed command words checked against a scroll register predictor.
module video_scroll_address_registers_tb;
    import vsar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_WORDS   = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 8;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              wait_idle;
    } t_cmd_word;

    typedef struct packed {
        logic [ADDR_W-1:0]   vram_addr;
        logic [ACCESS_W-1:0] access_addr;
        logic                access_valid;
        logic [FINE_W-1:0]   fine_x_scroll;
        logic                write_toggle;
        logic                addr_bit12;
    } t_scroll_result;

    logic i_clk;
    logic i_rst_n;

    vsar_in_if  cmd_if ();
    vsar_out_if res_if ();

    video_scroll_address_registers u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    t_cmd_word      cmd_words[$];
    t_scroll_result expected_results[$];
    t_state         shadow_regs = '0;

    t_cmd_word      next_word;
    t_scroll_result got_result;
    t_scroll_result want_result;
    t_scroll_result pred_result;
    logic           cmd_taken = 1'b0;
    logic           drain_next = 1'b0;
    int             burst_left = 1;
    int             gap_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;
    int             stall_tick = 0;
    int             cycles = 0;
    int             error_count = 0;
    int             results_checked = 0;
    int             idle_waits = 0;
    int             cmd_count[16];

    function automatic t_scroll_result step_scroll_regs(input logic [CMD_W-1:0] cmd,
                                                        input logic [BYTE_W-1:0] b);
        t_scroll_result r;
        logic [2:0]     fy;
        r = '0;
        case (cmd)
            CMD_CTRL: begin
                shadow_regs.temp_addr[11:10] = b[1:0];
                shadow_regs.step_by_row      = b[2];
            end
            CMD_SCROLL: begin
                if (shadow_regs.toggle) begin
                    shadow_regs.temp_addr[9:5]   = b[7:3];
                    shadow_regs.temp_addr[14:12] = b[2:0];
                end else begin
                    shadow_regs.temp_addr[4:0] = b[7:3];
                    shadow_regs.fine_x         = b[2:0];
                end
                shadow_regs.toggle = ~shadow_regs.toggle;
            end
            CMD_ADDR: begin
                if (shadow_regs.toggle) begin
                    shadow_regs.temp_addr[7:0] = b;
                    shadow_regs.cur_addr       = shadow_regs.temp_addr;
                    shadow_regs.line12_flag    = shadow_regs.temp_addr[12];
                end else begin
                    shadow_regs.temp_addr = {1'b0, b[5:0], shadow_regs.temp_addr[7:0]};
                end
                shadow_regs.toggle = ~shadow_regs.toggle;
            end
            CMD_DATA: begin
                r.access_addr  = shadow_regs.cur_addr[13:0];
                r.access_valid = 1'b1;
                shadow_regs.cur_addr = {1'b0, shadow_regs.cur_addr[13:0] +
                                        (shadow_regs.step_by_row ? 14'd32 : 14'd1)};
                shadow_regs.line12_flag = shadow_regs.cur_addr[12];
            end
            CMD_STATUS: begin
                shadow_regs.toggle = 1'b0;
            end
            CMD_COARSE: begin
                if (shadow_regs.cur_addr[4:0] == COARSE_LAST) begin
                    shadow_regs.cur_addr[4:0] = '0;
                    shadow_regs.cur_addr[10]  = ~shadow_regs.cur_addr[10];
                end else begin
                    shadow_regs.cur_addr = shadow_regs.cur_addr + 15'd1;
                end
            end
            CMD_FINE_Y: begin
                fy = shadow_regs.cur_addr[14:12];
                if (fy == FINE_LAST) begin
                    if (shadow_regs.cur_addr[9:5] == COARSE_LAST) begin
                        shadow_regs.cur_addr[9:0] = '0;
                    end else begin
                        shadow_regs.cur_addr = shadow_regs.cur_addr + 15'h20;
                        if (shadow_regs.cur_addr[9:5] >= ROW_WRAP) begin
                            shadow_regs.cur_addr[9:0] = '0;
                            shadow_regs.cur_addr[11]  = ~shadow_regs.cur_addr[11];
                        end
                    end
                end
                shadow_regs.cur_addr[14:12] = fy + 3'd1;
            end
            CMD_HCOPY: begin
                shadow_regs.cur_addr[10]  = shadow_regs.temp_addr[10];
                shadow_regs.cur_addr[4:0] = shadow_regs.temp_addr[4:0];
            end
            CMD_VCOPY: begin
                shadow_regs.cur_addr = shadow_regs.temp_addr;
            end
            default: ;
        endcase
        r.vram_addr     = shadow_regs.cur_addr;
        r.fine_x_scroll = shadow_regs.fine_x;
        r.write_toggle  = shadow_regs.toggle;
        r.addr_bit12    = shadow_regs.line12_flag;
        return r;
    endfunction

    task automatic push_word(input int cmd, input int b);
        t_cmd_word w;
        w.cmd       = CMD_W'(cmd);
        w.data_byte = BYTE_W'(b);
        w.wait_idle = drain_next;
        drain_next  = 1'b0;
        cmd_words   = {cmd_words, w};
    endtask

    task automatic push_scroll_pair();
        push_word(CMD_STATUS, $urandom_range(0, 255));
        push_word(CMD_SCROLL, $urandom_range(0, 255));
        push_word(CMD_SCROLL, $urandom_range(0, 255));
    endtask

    task automatic fill_directed();
        push_word(CMD_CTRL,   8'h00);
        push_word(CMD_ADDR,   8'h3f);
        push_word(CMD_ADDR,   8'hff);
        push_word(CMD_DATA,   8'h00);
        push_word(CMD_CTRL,   8'hff);
        push_word(CMD_ADDR,   8'hff);
        push_word(CMD_ADDR,   8'he0);
        push_word(CMD_DATA,   8'hff);
        push_word(CMD_STATUS, 8'h00);
        push_word(CMD_SCROLL, 8'hff);
        push_word(CMD_SCROLL, 8'hff);
        push_word(CMD_VCOPY,  8'h00);
        push_word(CMD_COARSE, 8'h00);
        push_word(CMD_FINE_Y, 8'h00);
        push_word(CMD_SCROLL, 8'h00);
        push_word(CMD_SCROLL, 8'hef);
        push_word(CMD_VCOPY,  8'h00);
        push_word(CMD_FINE_Y, 8'h00);
        push_word(CMD_FINE_Y, 8'h00);
        push_word(CMD_HCOPY,  8'h00);
        push_word(CMD_SPARE_LO, 8'hff);
        push_word(CMD_SPARE_HI, 8'h00);
        push_word(CMD_SCROLL, 8'h55);
        push_word(CMD_STATUS, 8'h00);
        push_word(CMD_SCROLL, 8'haa);
    endtask

    task automatic fill_random();
        int n;
        int marks;
        marks = 0;
        while (cmd_words.size() < RANDOM_WORDS) begin
            if (cmd_words.size() > (marks + 1) * 600) begin
                drain_next = 1'b1;
                marks++;
            end
            case ($urandom_range(0, 9))
                0: push_word(CMD_CTRL, $urandom_range(0, 255));
                1: push_scroll_pair();
                2: begin
                    push_word(CMD_STATUS, $urandom_range(0, 255));
                    push_word(CMD_ADDR, $urandom_range(0, 255));
                    push_word(CMD_ADDR, $urandom_range(0, 255));
                end
                3: begin
                    n = $urandom_range(1, 8);
                    repeat (n) push_word(CMD_DATA, $urandom_range(0, 255));
                end
                4: begin
                    n = $urandom_range(1, 40);
                    repeat (n) push_word(CMD_COARSE, $urandom_range(0, 255));
                    push_word(CMD_FINE_Y, $urandom_range(0, 255));
                    push_word(CMD_HCOPY, $urandom_range(0, 255));
                end
                5: begin
                    push_scroll_pair();
                    push_word(CMD_VCOPY, $urandom_range(0, 255));
                end
                6: begin
                    n = $urandom_range(4, 20);
                    repeat (n) push_word(CMD_FINE_Y, $urandom_range(0, 255));
                end
                7, 8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_word($urandom_range(0, 15), $urandom_range(0, 255));
                end
                default: push_word($urandom_range(0, 1) ? CMD_SCROLL : CMD_ADDR,
                                   $urandom_range(0, 255));
            endcase
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("video_scroll_address_registers test failed");
            $finish;
        end
    end

    // Driver: present the next word at the falling edge, in bursts with gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid     <= 1'b0;
            cmd_if.cmd       <= CMD_CTRL;
            cmd_if.data_byte <= '0;
        end else if (cmd_if.valid && !cmd_taken) begin
        end else if (gap_left > 0) begin
            gap_left--;
            cmd_if.valid <= 1'b0;
        end else if (cmd_words.size() == 0 ||
                     (cmd_words[0].wait_idle && expected_results.size() != 0)) begin
            cmd_if.valid <= 1'b0;
        end else begin
            next_word = cmd_words[0];
            cmd_words.delete(0);
            if (next_word.wait_idle) idle_waits++;
            cmd_if.valid     <= 1'b1;
            cmd_if.cmd       <= next_word.cmd;
            cmd_if.data_byte <= next_word.data_byte;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // Receiver: drive ready from one of four stall patterns, picked anew at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 200);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= (stall_tick % 3 != 0);
                default: res_if.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Monitor: check each result word, then predict for each accepted command.
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_result.vram_addr     = res_if.vram_addr;
            got_result.access_addr   = res_if.access_addr;
            got_result.access_valid  = res_if.access_valid;
            got_result.fine_x_scroll = res_if.fine_x_scroll;
            got_result.write_toggle  = res_if.write_toggle;
            got_result.addr_bit12    = res_if.addr_bit12;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result word %h at cycle %0d", got_result, cycles);
            end else begin
                want_result = expected_results[0];
                expected_results.delete(0);
                results_checked++;
                if (got_result.vram_addr     !== want_result.vram_addr     ||
                    got_result.access_addr   !== want_result.access_addr   ||
                    got_result.access_valid  !== want_result.access_valid  ||
                    got_result.fine_x_scroll !== want_result.fine_x_scroll ||
                    got_result.write_toggle  !== want_result.write_toggle  ||
                    got_result.addr_bit12    !== want_result.addr_bit12) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $write("mismatch at cycle %0d (expected/actual): vram %h/%h ",
                               cycles, want_result.vram_addr, got_result.vram_addr);
                        $write("access %h/%h acc_v %b/%b ",
                               want_result.access_addr, got_result.access_addr,
                               want_result.access_valid, got_result.access_valid);
                        $display("fine_x %0d/%0d toggle %b/%b bit12 %b/%b",
                                 want_result.fine_x_scroll, got_result.fine_x_scroll,
                                 want_result.write_toggle, got_result.write_toggle,
                                 want_result.addr_bit12, got_result.addr_bit12);
                    end
                end
            end
        end
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            cmd_count[cmd_if.cmd]++;
            pred_result      = step_scroll_regs(cmd_if.cmd, cmd_if.data_byte);
            expected_results = {expected_results, pred_result};
        end
    end

    initial begin
        foreach (cmd_count[k]) cmd_count[k] = 0;
        i_rst_n = 1'b0;
        fill_directed();
        fill_random();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_words.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) error_count++;
        $display("covered %0d bus writes, %0d data accesses, %0d status reads,",
                 cmd_count[CMD_CTRL] + cmd_count[CMD_SCROLL] + cmd_count[CMD_ADDR],
                 cmd_count[CMD_DATA], cmd_count[CMD_STATUS]);
        $display("%0d render steps, %0d idle waits; %0d results checked, %0d errors",
                 cmd_count[CMD_COARSE] + cmd_count[CMD_FINE_Y] + cmd_count[CMD_HCOPY] +
                 cmd_count[CMD_VCOPY], idle_waits, results_checked, error_count);
        if (error_count == 0) begin
            $display("video_scroll_address_registers test passed");
        end else begin
            $display("video_scroll_address_registers test failed");
        end
        $finish;
    end

endmodule
